// File: hdl/shdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper driver health monitor package
// Shared types, codes and constants for the monitor's controller and datapath.
// ----------------------------------------------------------------------------
package shdm_pkg;

   // Controller states
   typedef enum logic [0:0] {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   // Result event codes
   typedef enum logic [3:0] {
      EV_QUIET         = 4'd0,
      EV_LINK_LOST     = 4'd1,
      EV_STILL_LOST    = 4'd2,
      EV_RESTORED      = 4'd3,
      EV_SHDN_OVERTEMP = 4'd4,
      EV_SHDN_OTHER    = 4'd5,
      EV_THERMAL_WARN  = 4'd6,
      EV_WARN_REDUCE   = 4'd7,
      EV_OTHER_FAULT   = 4'd8
   } event_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_ERROR_MASK    = 3'd0,
      CSR_TWARN_MASK    = 3'd1,
      CSR_TSHDN_MASK    = 3'd2,
      CSR_UVLO_MASK     = 3'd3,
      CSR_OCD_MASK      = 3'd4,
      CSR_STALL_MASK    = 3'd5,
      CSR_KVAL_STEP     = 3'd6,
      CSR_STOP_ON_ERROR = 3'd7
   } csr_index_type;

   // Configuration reset values
   localparam logic [15:0] ERROR_MASK_RST = 16'h7E00;
   localparam logic [15:0] TWARN_MASK_RST = 16'h0400;
   localparam logic [15:0] TSHDN_MASK_RST = 16'h0800;
   localparam logic [15:0] UVLO_MASK_RST  = 16'h0200;
   localparam logic [15:0] OCD_MASK_RST   = 16'h1000;
   localparam logic [15:0] STALL_MASK_RST = 16'h6000;
   localparam logic [6:0]  KVAL_STEP_RST  = 7'd1;

   // Status decode constants
   localparam logic [15:0] STATUS_ALL_ONES   = 16'hFFFF;
   localparam logic [15:0] STATUS_ALL_ZEROS  = 16'h0000;
   localparam int          HIZ_BIT           = 0;
   localparam logic [8:0]  LINK_REMIND_LIMIT = 9'd240;
   localparam logic [3:0]  WARN_LIMIT        = 4'd4;

   // Per-driver record
   typedef struct packed {
      logic [7:0] link_loss_count;
      logic [2:0] warning_count;
      logic       warning_flag;
      logic       overtemp_flag;
      logic       hiz_flag;
   } drv_rec_type;

   // One result
   typedef struct packed {
      logic       undervoltage;
      logic       stall_res;
      logic       overcurrent;
      logic       halt_request;
      logic       reinit_request;
      logic [7:0] kval_value;
      logic       kval_write;
      event_type  event_res;
   } result_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture request, start record read
      logic commit;  // write record back, load result register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;  // result register empty or being drained now
   } dp_stat_type;

endpackage

// File: hdl/shdm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper driver health monitor controller
// Two-state sequencer: capture a request, then evaluate and commit it.
// ----------------------------------------------------------------------------
module shdm_ctrl
   import shdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_tvalid) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            if (stat.out_free) begin
               state_in = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         CTL_EXEC: begin
            cmd.commit = stat.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/shdm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper driver health monitor datapath
// Config registers, per-driver record memory, status classifier, result reg.
// ----------------------------------------------------------------------------
module shdm_datapath
   import shdm_pkg::*;
#(
   parameter int NUM_DRIVERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [3:0]  driver,
   input  logic [15:0] status_word,
   input  logic [7:0]  current_kval,
   input  logic        abort,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output result_type  result
);

   localparam int AW = (NUM_DRIVERS > 1) ? $clog2(NUM_DRIVERS) : 1;
   localparam logic [6:0] NUM_DRV_W = 7'(NUM_DRIVERS);

   // Configuration registers
   logic [15:0] error_mask_ff, twarn_mask_ff, tshdn_mask_ff;
   logic [15:0] uvlo_mask_ff, ocd_mask_ff, stall_mask_ff;
   logic [6:0]  kval_step_ff;
   logic        stop_on_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_mask_ff    <= ERROR_MASK_RST;
         twarn_mask_ff    <= TWARN_MASK_RST;
         tshdn_mask_ff    <= TSHDN_MASK_RST;
         uvlo_mask_ff     <= UVLO_MASK_RST;
         ocd_mask_ff      <= OCD_MASK_RST;
         stall_mask_ff    <= STALL_MASK_RST;
         kval_step_ff     <= KVAL_STEP_RST;
         stop_on_error_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ERROR_MASK:    error_mask_ff    <= csr_wdata;
            CSR_TWARN_MASK:    twarn_mask_ff    <= csr_wdata;
            CSR_TSHDN_MASK:    tshdn_mask_ff    <= csr_wdata;
            CSR_UVLO_MASK:     uvlo_mask_ff     <= csr_wdata;
            CSR_OCD_MASK:      ocd_mask_ff      <= csr_wdata;
            CSR_STALL_MASK:    stall_mask_ff    <= csr_wdata;
            CSR_KVAL_STEP:     kval_step_ff     <= csr_wdata[6:0];
            CSR_STOP_ON_ERROR: stop_on_error_ff <= csr_wdata[0];
            default:           stop_on_error_ff <= stop_on_error_ff;
         endcase
      end
   end

   // Captured request
   logic [AW-1:0] addr_ff;
   logic [15:0]   status_ff;
   logic [7:0]    kval_ff;
   logic          active_ff;  // not aborted and driver in range

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff   <= AW'(driver);
         status_ff <= status_word;
         kval_ff   <= current_kval;
         active_ff <= !abort && ({3'b000, driver} < NUM_DRV_W);
      end
   end

   // Per-driver record memory, registered read
   drv_rec_type rec_mem [NUM_DRIVERS];
   drv_rec_type rd_rec_ff;
   drv_rec_type new_rec;
   logic        rec_we;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_rec_ff <= rec_mem[AW'(driver)];
      end
      if (rec_we) begin
         rec_mem[addr_ff] <= new_rec;
      end
   end

   // Valid bits: an unwritten entry reads as all zeros
   logic [NUM_DRIVERS-1:0] vld_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            rd_vld_ff <= vld_ff[AW'(driver)];
         end
         if (rec_we) begin
            vld_ff[addr_ff] <= 1'b1;
         end
      end
   end

   assign rec_we = cmd.commit && active_ff;

   // Status classification and record update
   drv_rec_type cur_rec;
   result_type  res_in;
   logic [15:0] inv;
   logic        lost;
   logic [8:0]  llc_inc;
   logic [3:0]  wc_inc;
   logic [8:0]  step_x2;
   logic [8:0]  step_x1;
   logic [8:0]  kval_w;

   always_comb begin
      cur_rec = rd_vld_ff ? rd_rec_ff : '0;
      new_rec = cur_rec;
      res_in  = '0;
      inv     = ~status_ff;
      lost    = (status_ff == STATUS_ALL_ZEROS) || (status_ff == STATUS_ALL_ONES);
      llc_inc = {1'b0, cur_rec.link_loss_count} + 9'd1;
      wc_inc  = {1'b0, cur_rec.warning_count} + 4'd1;
      step_x1 = {2'b00, kval_step_ff};
      step_x2 = {1'b0, kval_step_ff, 1'b0};
      kval_w  = {1'b0, kval_ff};

      if (lost) begin
         // link lost: first loss, or count toward the reminder
         if (cur_rec.link_loss_count == 8'd0) begin
            new_rec.link_loss_count = 8'd1;
            res_in.event_res        = EV_LINK_LOST;
         end else if (llc_inc > LINK_REMIND_LIMIT) begin
            new_rec.link_loss_count = 8'd1;
            res_in.event_res        = EV_STILL_LOST;
         end else begin
            new_rec.link_loss_count = llc_inc[7:0];
         end
      end else if (cur_rec.link_loss_count != 8'd0) begin
         // first good word after a loss
         new_rec.link_loss_count = 8'd0;
         res_in.event_res        = EV_RESTORED;
         res_in.reinit_request   = 1'b1;
      end else if ((inv & error_mask_ff) != 16'd0) begin
         if (status_ff[HIZ_BIT]) begin
            // bridges in hi-Z
            new_rec.hiz_flag = 1'b1;
            if ((inv & twarn_mask_ff) != 16'd0) begin
               new_rec.overtemp_flag = 1'b1;
               res_in.kval_write     = 1'b1;
               res_in.kval_value     = (step_x2 >= kval_w) ? 8'd0 : 8'(kval_w - step_x2);
               res_in.event_res      = EV_SHDN_OVERTEMP;
            end else begin
               new_rec.overtemp_flag = 1'b0;
               res_in.event_res      = EV_SHDN_OTHER;
            end
         end else begin
            new_rec.hiz_flag = 1'b0;
            if ((inv & twarn_mask_ff) != 16'd0) begin
               new_rec.warning_flag = 1'b1;
               if (wc_inc > WARN_LIMIT) begin
                  res_in.kval_write     = 1'b1;
                  res_in.kval_value     = (step_x1 >= kval_w) ? 8'd0 : 8'(kval_w - step_x1);
                  res_in.event_res      = EV_WARN_REDUCE;
                  new_rec.warning_count = 3'd0;
               end else begin
                  res_in.event_res      = EV_THERMAL_WARN;
                  new_rec.warning_count = wc_inc[2:0];
               end
            end else begin
               res_in.event_res = EV_OTHER_FAULT;
            end
         end
         res_in.halt_request = stop_on_error_ff &&
            ((inv & (uvlo_mask_ff | twarn_mask_ff | tshdn_mask_ff)) != 16'd0);
         res_in.overcurrent  = (inv & ocd_mask_ff) != 16'd0;
         res_in.stall_res    = (inv & stall_mask_ff) != 16'd0;
         res_in.undervoltage = (inv & uvlo_mask_ff) != 16'd0;
      end else begin
         // healthy word clears thermal history
         new_rec.overtemp_flag = 1'b0;
         new_rec.warning_count = 3'd0;
         new_rec.warning_flag  = 1'b0;
      end

      // aborted or out-of-range request gives a quiet result
      if (!active_ff) begin
         res_in = '0;
      end
   end

   // Result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         result <= res_in;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

endmodule

// File: hdl/stepper_driver_health_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper driver health monitor
// Classifies polled driver status words and keeps a per-driver fault record.
// ----------------------------------------------------------------------------
// Result: rsp_tvalid is registered at the commit in CTL_EXEC, which follows the
//   capture in CTL_IDLE; a held result stalls the commit. No new request is
//   taken until then; the record is read at capture, written back at commit.
// Reset: control state and config registers return to defaults at once;
//   per-driver valid bits clear so every record reads as zero. No clear pass.
// ----------------------------------------------------------------------------
module stepper_driver_health_monitor_top
   import shdm_pkg::*;
#(
   parameter int NUM_DRIVERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // driver[3:0], status_word[19:4], current_kval[27:20]
   input  logic        req_tuser,   // abort
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // event_res[3:0], kval_write[4], kval_value[12:5],
                                    // reinit_request[13], halt_request[14],
                                    // overcurrent[15], stall_res[16], undervoltage[17]
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   result_type  result;

   assign csr_ready = 1'b1;

   shdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   shdm_datapath #(
      .NUM_DRIVERS (NUM_DRIVERS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .driver       (req_tdata[3:0]),
      .status_word  (req_tdata[19:4]),
      .current_kval (req_tdata[27:20]),
      .abort        (req_tuser),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .result       (result)
   );

   // pack result, last field lowest
   assign rsp_tdata = {6'd0, result};

endmodule

// File: tb/stepper_driver_health_monitor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper driver health monitor checker
// Watches the request, result and register write channels. Each accepted
// request is classified against a private copy of the per-driver records and
// registers, and the predicted report is compared field by field with the
// next result that the block hands out.
// ----------------------------------------------------------------------------
module stepper_driver_health_monitor_checker
   import shdm_pkg::*;
#(
   parameter int NUM_DRIVERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // driver[3:0], status_word[19:4], current_kval[27:20]
   input  logic        req_tuser,   // abort
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // event_res[3:0], kval_write[4], kval_value[12:5],
                                    // reinit_request[13], halt_request[14],
                                    // overcurrent[15], stall_res[16], undervoltage[17]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          reports_owed
);

   // Register copies
   logic [15:0] fault_mask;
   logic [15:0] twarn_mask;
   logic [15:0] tshdn_mask;
   logic [15:0] uvlo_mask;
   logic [15:0] ocd_mask;
   logic [15:0] step_loss_mask;
   logic [6:0]  kval_step;
   logic        halt_enable;

   // Per-driver records and reports still owed by the block
   drv_rec_type driver_rec [NUM_DRIVERS];
   result_type  predicted_reports [$];

   // Hold voltage lowered by cut, floored at zero
   function automatic logic [7:0] lower_kval(logic [7:0] kval, logic [8:0] cut);
      return (cut >= {1'b0, kval}) ? 8'd0 : kval - cut[7:0];
   endfunction

   // Classify one status word and update that driver's record
   function automatic result_type classify_status(logic [3:0] drv, logic [15:0] status,
                                                  logic [7:0] kval, logic abort_bit);
      result_type  r;
      logic [15:0] low_bits;
      logic [8:0]  lcount;
      logic [3:0]  wcount;
      r = '0;
      r.event_res = EV_QUIET;
      if (abort_bit || drv >= NUM_DRIVERS) return r;
      low_bits = ~status;
      if (status == STATUS_ALL_ZEROS || status == STATUS_ALL_ONES) begin
         // link lost, remind every 240 further lost words
         if (driver_rec[drv].link_loss_count == '0) begin
            driver_rec[drv].link_loss_count = 8'd1;
            r.event_res = EV_LINK_LOST;
         end else begin
            lcount = {1'b0, driver_rec[drv].link_loss_count} + 9'd1;
            if (lcount > LINK_REMIND_LIMIT) begin
               lcount = 9'd1;
               r.event_res = EV_STILL_LOST;
            end
            driver_rec[drv].link_loss_count = lcount[7:0];
         end
      end else if (driver_rec[drv].link_loss_count != '0) begin
         driver_rec[drv].link_loss_count = '0;
         r.event_res = EV_RESTORED;
         r.reinit_request = 1'b1;
      end else if ((low_bits & fault_mask) != '0) begin
         if (status[HIZ_BIT]) begin
            // driver in hi-Z shutdown
            driver_rec[drv].hiz_flag = 1'b1;
            if ((low_bits & twarn_mask) != '0) begin
               driver_rec[drv].overtemp_flag = 1'b1;
               r.kval_write = 1'b1;
               r.kval_value = lower_kval(kval, {1'b0, kval_step, 1'b0});
               r.event_res = EV_SHDN_OVERTEMP;
            end else begin
               driver_rec[drv].overtemp_flag = 1'b0;
               r.event_res = EV_SHDN_OTHER;
            end
         end else begin
            driver_rec[drv].hiz_flag = 1'b0;
            if ((low_bits & twarn_mask) != '0) begin
               // repeated warnings cost one step
               wcount = {1'b0, driver_rec[drv].warning_count} + 4'd1;
               driver_rec[drv].warning_flag = 1'b1;
               if (wcount > WARN_LIMIT) begin
                  r.kval_write = 1'b1;
                  r.kval_value = lower_kval(kval, {2'b0, kval_step});
                  wcount = '0;
                  r.event_res = EV_WARN_REDUCE;
               end else begin
                  r.event_res = EV_THERMAL_WARN;
               end
               driver_rec[drv].warning_count = wcount[2:0];
            end else begin
               r.event_res = EV_OTHER_FAULT;
            end
         end
         r.halt_request = halt_enable &&
                          ((low_bits & (uvlo_mask | twarn_mask | tshdn_mask)) != '0);
         r.overcurrent  = (low_bits & ocd_mask) != '0;
         r.stall_res    = (low_bits & step_loss_mask) != '0;
         r.undervoltage = (low_bits & uvlo_mask) != '0;
      end else begin
         // clean status clears the warning history
         driver_rec[drv].overtemp_flag = 1'b0;
         driver_rec[drv].warning_count = '0;
         driver_rec[drv].warning_flag = 1'b0;
      end
      return r;
   endfunction

   task automatic compare_field(string label, int want, int seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, seen);
         mismatch_count++;
      end
   endtask

   // Channel monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         fault_mask     = ERROR_MASK_RST;
         twarn_mask     = TWARN_MASK_RST;
         tshdn_mask     = TSHDN_MASK_RST;
         uvlo_mask      = UVLO_MASK_RST;
         ocd_mask       = OCD_MASK_RST;
         step_loss_mask = STALL_MASK_RST;
         kval_step      = KVAL_STEP_RST;
         halt_enable    = 1'b0;
         for (int i = 0; i < NUM_DRIVERS; i++) driver_rec[i] = '0;
         predicted_reports.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ERROR_MASK:    fault_mask = csr_wdata;
               CSR_TWARN_MASK:    twarn_mask = csr_wdata;
               CSR_TSHDN_MASK:    tshdn_mask = csr_wdata;
               CSR_UVLO_MASK:     uvlo_mask = csr_wdata;
               CSR_OCD_MASK:      ocd_mask = csr_wdata;
               CSR_STALL_MASK:    step_loss_mask = csr_wdata;
               CSR_KVAL_STEP:     kval_step = csr_wdata[6:0];
               CSR_STOP_ON_ERROR: halt_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_reports.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time,
                        rsp_tdata);
               mismatch_count++;
            end else begin
               want = predicted_reports.pop_front();
               compare_field("event_res", int'(want.event_res), int'(rsp_tdata[3:0]));
               compare_field("kval_write", want.kval_write, rsp_tdata[4]);
               compare_field("kval_value", want.kval_value, rsp_tdata[12:5]);
               compare_field("reinit_request", want.reinit_request, rsp_tdata[13]);
               compare_field("halt_request", want.halt_request, rsp_tdata[14]);
               compare_field("overcurrent", want.overcurrent, rsp_tdata[15]);
               compare_field("stall_res", want.stall_res, rsp_tdata[16]);
               compare_field("undervoltage", want.undervoltage, rsp_tdata[17]);
            end
         end
         if (req_tvalid && req_tready)
            predicted_reports.push_back(classify_status(req_tdata[3:0], req_tdata[19:4],
                                                        req_tdata[27:20], req_tuser));
      end
      reports_owed = predicted_reports.size();
   end

endmodule

// File: tb/stepper_driver_health_monitor_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper driver health monitor testbench
// Drives directed and random status polls through the monitor under several
// register settings, with random gaps on both stream sides, and leaves the
// checking to the checker instance beside the block.
// ----------------------------------------------------------------------------
module stepper_driver_health_monitor_top_test;
   import shdm_pkg::*;

   localparam int DRIVERS     = 16;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_ERROR_MASK;
   logic [15:0] csr_wdata = '0;

   int          mismatch_count;
   int          reports_owed;
   int          cycle_count = 0;
   int          tx_calm = 0;
   int          rx_calm = 0;
   logic [15:0] cfg_now [8];

   stepper_driver_health_monitor_top #(.NUM_DRIVERS(DRIVERS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   stepper_driver_health_monitor_checker #(.NUM_DRIVERS(DRIVERS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .reports_owed   (reports_owed)
   );

   always #6 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Wait before one request or result: random, with calm stretches of none
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   // Whole mask or a random part of it
   function automatic logic [15:0] some_bits(logic [15:0] mask);
      return mask & ($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom));
   endfunction

   // Result side: random stalls between results
   initial begin : rsp_sink
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait(rx_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // One status poll; entered and left at a falling edge with tvalid still high
   task automatic send_request(logic [3:0] drv, logic [15:0] status, logic [7:0] kval,
                               logic abort_bit);
      int gap;
      gap = draw_wait(tx_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, kval, status, drv};
      req_tuser  <= abort_bit;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Mostly well-formed fault words built from the current masks
   task automatic send_random(logic [3:0] base);
      logic [3:0]  drv;
      logic [15:0] status;
      logic [7:0]  kval;
      drv = ($urandom_range(0, 6) == 0) ? 4'($urandom) : base + 4'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0: status = $urandom_range(0, 1) ? STATUS_ALL_ONES : STATUS_ALL_ZEROS;
         1: status = 16'($urandom);
         2: status = {15'h7FFF, 1'($urandom)};
         default: begin
            status = 16'hFFFF;
            if ($urandom_range(0, 1) == 0) status &= ~some_bits(cfg_now[CSR_TWARN_MASK]);
            if ($urandom_range(0, 3) == 0) status &= ~some_bits(cfg_now[CSR_TSHDN_MASK]);
            if ($urandom_range(0, 3) == 0) status &= ~some_bits(cfg_now[CSR_UVLO_MASK]);
            if ($urandom_range(0, 3) == 0) status &= ~some_bits(cfg_now[CSR_OCD_MASK]);
            if ($urandom_range(0, 3) == 0) status &= ~some_bits(cfg_now[CSR_STALL_MASK]);
            if ($urandom_range(0, 3) == 0) status &= ~some_bits(cfg_now[CSR_ERROR_MASK]);
            status[HIZ_BIT] = ($urandom_range(0, 2) == 0);
         end
      endcase
      case ($urandom_range(0, 4))
         0:       kval = 8'd0;
         1:       kval = 8'hFF;
         default: kval = 8'($urandom);
      endcase
      send_request(drv, status, kval, $urandom_range(0, 19) == 0);
   endtask

   // Let every owed result drain, then a short settle before register writes
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (reports_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_registers();
      foreach (cfg_now[i]) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= cfg_now[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count);
      logic [3:0] base;
      base = 4'($urandom);
      wait_idle();
      load_registers();
      repeat (count) send_random(base);
   endtask

   // Stimulus
   initial begin : stimulus
      logic [3:0] burst_drv;
      int         lost_seen;
      cfg_now[CSR_ERROR_MASK]    = ERROR_MASK_RST;
      cfg_now[CSR_TWARN_MASK]    = TWARN_MASK_RST;
      cfg_now[CSR_TSHDN_MASK]    = TSHDN_MASK_RST;
      cfg_now[CSR_UVLO_MASK]     = UVLO_MASK_RST;
      cfg_now[CSR_OCD_MASK]      = OCD_MASK_RST;
      cfg_now[CSR_STALL_MASK]    = STALL_MASK_RST;
      cfg_now[CSR_KVAL_STEP]     = 16'(KVAL_STEP_RST);
      cfg_now[CSR_STOP_ON_ERROR] = 16'd0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: lost, lost again, restored, clean
      send_request(4'd0, 16'h0000, 8'd0, 1'b0);
      send_request(4'd0, 16'hFFFF, 8'hFF, 1'b0);
      send_request(4'd0, 16'h7E00, 8'd10, 1'b0);
      send_request(4'd0, 16'h7E00, 8'd10, 1'b0);
      // hi-Z with thermal warning, floor at zero and from the top
      send_request(4'd1, 16'h7A01, 8'd0, 1'b0);
      send_request(4'd1, 16'h7A01, 8'hFF, 1'b0);
      // hi-Z with step loss only
      send_request(4'd2, 16'h5E01, 8'd40, 1'b0);
      // five warnings in a row, the last lowers hold voltage
      repeat (4) send_request(4'd3, 16'h7A00, 8'd7, 1'b0);
      send_request(4'd3, 16'h7A00, 8'd1, 1'b0);
      // undervoltage with overcurrent, no hi-Z, no warning
      send_request(4'd4, 16'h6C00, 8'd50, 1'b0);
      // aborted poll leaves the record alone
      send_request(4'd5, 16'h0000, 8'hFF, 1'b1);
      send_request(4'd5, 16'hFFFF, 8'd0, 1'b0);
      send_request(4'd15, 16'hFFFE, 8'h80, 1'b0);
      send_request(4'd15, 16'h0001, 8'h80, 1'b0);
      send_request(4'd14, 16'hFFFF, 8'h55, 1'b1);
      send_request(4'd3, 16'hFFFE, 8'hAA, 1'b0);

      // Long loss on one driver to reach the reminder, then recovery
      burst_drv = 4'($urandom);
      lost_seen = 0;
      while (lost_seen < 245) begin
         case ($urandom_range(0, 11))
            0: send_request(burst_drv ^ 4'd8, 16'($urandom), 8'($urandom), 1'b0);
            1: send_request(burst_drv, 16'($urandom), 8'($urandom), 1'b1);
            default: begin
               send_request(burst_drv, $urandom_range(0, 1) ? STATUS_ALL_ONES
                                                            : STATUS_ALL_ZEROS,
                            8'($urandom), 1'b0);
               lost_seen++;
            end
         endcase
      end
      send_request(burst_drv, 16'hFFFE, 8'd9, 1'b0);

      // Defaults with halt enabled and the largest step
      cfg_now[CSR_KVAL_STEP]     = 16'd127;
      cfg_now[CSR_STOP_ON_ERROR] = 16'd1;
      random_phase(30);

      // Every bit counts, no step
      foreach (cfg_now[i]) cfg_now[i] = 16'hFFFF;
      cfg_now[CSR_KVAL_STEP]     = 16'd0;
      cfg_now[CSR_STOP_ON_ERROR] = 16'd1;
      random_phase(30);

      // Nothing counts as a fault
      foreach (cfg_now[i]) cfg_now[i] = 16'h0000;
      cfg_now[CSR_KVAL_STEP] = 16'd127;
      random_phase(20);

      // Random masks
      foreach (cfg_now[i]) cfg_now[i] = 16'($urandom);
      cfg_now[CSR_KVAL_STEP]     = 16'($urandom_range(0, 127));
      cfg_now[CSR_STOP_ON_ERROR] = 16'($urandom_range(0, 1));
      random_phase(35);

      // Back to the reset masks, small random step
      cfg_now[CSR_ERROR_MASK]    = ERROR_MASK_RST;
      cfg_now[CSR_TWARN_MASK]    = TWARN_MASK_RST;
      cfg_now[CSR_TSHDN_MASK]    = TSHDN_MASK_RST;
      cfg_now[CSR_UVLO_MASK]     = UVLO_MASK_RST;
      cfg_now[CSR_OCD_MASK]      = OCD_MASK_RST;
      cfg_now[CSR_STALL_MASK]    = STALL_MASK_RST;
      cfg_now[CSR_KVAL_STEP]     = 16'($urandom_range(1, 10));
      cfg_now[CSR_STOP_ON_ERROR] = 16'd1;
      random_phase(30);

      // Drain and settle, then the verdict
      wait_idle();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
